// File: hw/rtl/dnsv_pkg.sv
`timescale 1ns / 1ps

package dnsv_pkg;

  localparam int unsigned MaxLen = 512;
  localparam int unsigned PosW   = $clog2(MaxLen + 1);
  localparam int unsigned SkipW  = 16;

  localparam logic [PosW-1:0] PosRcode   = PosW'(3);
  localparam logic [PosW-1:0] PosAnHi    = PosW'(6);
  localparam logic [PosW-1:0] PosAnLo    = PosW'(7);
  localparam logic [PosW-1:0] PosHdrLast = PosW'(11);
  localparam logic [PosW-1:0] HdrLen     = PosW'(12);
  localparam logic [PosW-1:0] MaxPos     = PosW'(MaxLen);

  localparam logic [3:0]  RcodeNxdomain = 4'd3;
  localparam logic [1:0]  PtrMark       = 2'b11;
  localparam logic [15:0] TypeA         = 16'd1;
  localparam logic [15:0] ClassIn       = 16'd1;
  localparam logic [15:0] RdLenA        = 16'd4;
  localparam logic [3:0]  FixedLast     = 4'd9;
  localparam logic [3:0]  RdataLast     = 4'd3;

  typedef enum logic [6:0] {
    PH_HEADER    = 7'b0000001,
    PH_QNAME     = 7'b0000010,
    PH_ANS_FIRST = 7'b0000100,
    PH_ANS_LABEL = 7'b0001000,
    PH_FIXED     = 7'b0010000,
    PH_RDATA     = 7'b0100000,
    PH_DONE      = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    ST_NXDOMAIN   = 3'd0,
    ST_RCODE_ERR  = 3'd1,
    ST_NO_ANSWERS = 3'd2,
    ST_FOUND      = 3'd3,
    ST_FAIL       = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  rcode;
    logic [31:0] address;
    logic        nxdomain;
    logic        sinkhole;
    logic        blocked;
  } verdict_t;

  function automatic logic is_sinkhole(logic [31:0] a);
    return (a == 32'h0000_0000) || (a == 32'h0000_0001) || (a == 32'h7F00_0001) ||
           (a == 32'h0000_00FF) || (a == 32'hFFFF_FFFF);
  endfunction

endpackage

// File: hw/rtl/dnsv_parser.sv
`timescale 1ns / 1ps

module dnsv_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output dnsv_pkg::verdict_t verdict_o
);
  import dnsv_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  phase_e           phase_q, phase_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [15:0]      total_q, total_d;
  logic [15:0]      seen_q, seen_d;
  logic [3:0]       rcode_q, rcode_d;
  logic [47:0]      rec_q, rec_d;
  logic [3:0]       fidx_q, fidx_d;
  logic [31:0]      addr_q, addr_d;
  logic             found_q, found_d;

  logic [7:0] b;
  assign b = data_byte_i;

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    total_d = total_q;
    seen_d  = seen_q;
    rcode_d = rcode_q;
    rec_d   = rec_q;
    fidx_d  = fidx_q;
    addr_d  = addr_q;
    found_d = found_q;
    if (pos_q < MaxPos) begin
      pos_d = pos_q + PosW'(1);
      if (phase_q == PH_HEADER) begin
        if (pos_q == PosRcode) rcode_d = b[3:0];
        if (pos_q == PosAnHi)  total_d = {b, 8'h00};
        if (pos_q == PosAnLo)  total_d = {total_q[15:8], b};
        if (pos_q == PosHdrLast) phase_d = PH_QNAME;
      end else if (phase_q == PH_DONE) begin
        phase_d = PH_DONE;
      end else if (skip_q != '0) begin
        skip_d = skip_q - SkipW'(1);
      end else begin
        unique case (phase_q)
          PH_QNAME: begin
            if (b == 8'h00) begin
              skip_d  = SkipW'(4);
              phase_d = PH_ANS_FIRST;
            end else if (b[7:6] == PtrMark) begin
              skip_d  = SkipW'(5);
              phase_d = PH_ANS_FIRST;
            end else begin
              skip_d = SkipW'(b);
            end
          end
          PH_ANS_FIRST: begin
            if (seen_q >= total_q) begin
              phase_d = PH_DONE;
            end else if (b[7:6] == PtrMark) begin
              phase_d = PH_FIXED;
              fidx_d  = '0;
              rec_d   = '0;
              skip_d  = SkipW'(1);
            end else if (b == 8'h00) begin
              phase_d = PH_FIXED;
              fidx_d  = '0;
              rec_d   = '0;
            end else begin
              skip_d  = SkipW'(b);
              phase_d = PH_ANS_LABEL;
            end
          end
          PH_ANS_LABEL: begin
            if (b == 8'h00) begin
              phase_d = PH_FIXED;
              fidx_d  = '0;
              rec_d   = '0;
            end else begin
              skip_d = SkipW'(b);
            end
          end
          PH_FIXED: begin
            if (fidx_q < 4'd4 || fidx_q >= 4'd8) rec_d = {rec_q[39:0], b};
            fidx_d = fidx_q + 4'd1;
            if (fidx_q >= FixedLast) begin
              if (rec_d[47:32] == TypeA && rec_d[31:16] == ClassIn &&
                  rec_d[15:0] == RdLenA) begin
                phase_d = PH_RDATA;
                fidx_d  = '0;
                addr_d  = '0;
              end else begin
                seen_d  = seen_q + 16'd1;
                skip_d  = rec_d[15:0];
                phase_d = PH_ANS_FIRST;
              end
            end
          end
          PH_RDATA: begin
            addr_d = {addr_q[23:0], b};
            fidx_d = fidx_q + 4'd1;
            if (fidx_q >= RdataLast) begin
              found_d = 1'b1;
              phase_d = PH_DONE;
            end
          end
          default: phase_d = PH_DONE;
        endcase
      end
    end
  end

  always_comb begin
    verdict_o = '0;
    verdict_o.rcode = rcode_d;
    if (pos_d < HdrLen) begin
      verdict_o.status = ST_FAIL;
    end else if (rcode_d == RcodeNxdomain) begin
      verdict_o.status   = ST_NXDOMAIN;
      verdict_o.nxdomain = 1'b1;
    end else if (rcode_d != 4'd0) begin
      verdict_o.status   = ST_RCODE_ERR;
      verdict_o.nxdomain = 1'b1;
    end else if (total_d == 16'd0) begin
      verdict_o.status   = ST_NO_ANSWERS;
      verdict_o.sinkhole = 1'b1;
    end else if (found_d) begin
      verdict_o.status   = ST_FOUND;
      verdict_o.address  = addr_d;
      verdict_o.sinkhole = is_sinkhole(addr_d);
    end else begin
      verdict_o.status = ST_FAIL;
    end
    verdict_o.blocked = verdict_o.nxdomain | verdict_o.sinkhole;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEADER;
      skip_q  <= '0;
      total_q <= '0;
      seen_q  <= '0;
      rcode_q <= '0;
      rec_q   <= '0;
      fidx_q  <= '0;
      addr_q  <= '0;
      found_q <= 1'b0;
    end else if (take_i) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        phase_q <= PH_HEADER;
        skip_q  <= '0;
        total_q <= '0;
        seen_q  <= '0;
        rcode_q <= '0;
        rec_q   <= '0;
        fidx_q  <= '0;
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        skip_q  <= skip_d;
        total_q <= total_d;
        seen_q  <= seen_d;
        rcode_q <= rcode_d;
        rec_q   <= rec_d;
        fidx_q  <= fidx_d;
        addr_q  <= addr_d;
        found_q <= found_d;
      end
    end
  end

endmodule

// File: hw/rtl/dns_response_verdict_parser.sv
`timescale 1ns / 1ps

// DNS response verdict parser.
// Input channel: one packet byte per beat (data_byte_i, last_byte_i) on
// in_valid_i / in_ready_o. Output channel: one verdict beat per packet on
// out_valid_o / out_ready_i, issued for the beat marked last_byte_i.
// Throughput: one byte per cycle unless the verdict register is full and
// not being drained; each byte is parsed in the cycle it is accepted by
// the header/name/record walker, so packets may follow back to back with no gap.
// The verdict is registered and shows on the outputs in the cycle after
// the last byte is accepted.
// Bytes beyond MaxLen are accepted but not parsed; their last mark still
// closes the packet.
// Reset clears the parser to the header phase and drops any pending
// verdict. When the receiver stalls, the verdict register holds and no
// input byte is taken: in_ready_o is low while the verdict register is
// full and not being drained.
module dns_response_verdict_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  rcode_value_o,
  output logic [31:0] address_o,
  output logic        nxdomain_flag_o,
  output logic        sinkhole_flag_o,
  output logic        blocked_o
);
  import dnsv_pkg::*;

  logic     accept;
  verdict_t verdict;
  verdict_t res_q;
  logic     out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dnsv_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .verdict_o   (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign rcode_value_o   = res_q.rcode;
  assign address_o       = res_q.address;
  assign nxdomain_flag_o = res_q.nxdomain;
  assign sinkhole_flag_o = res_q.sinkhole;
  assign blocked_o       = res_q.blocked;

  a_last_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> out_valid_o)
    else $error("last byte did not produce a verdict");

  a_fail_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FAIL |-> !blocked_o && address_o == 32'd0)
    else $error("parse failure with blocked or address set");

  a_no_answers_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_ANSWERS |->
      sinkhole_flag_o && address_o == 32'd0 && rcode_value_o == 4'd0)
    else $error("no-answer verdict malformed");

  a_nx_rcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NXDOMAIN |-> rcode_value_o == RcodeNxdomain && blocked_o)
    else $error("nxdomain verdict without rcode 3");

endmodule

// File: test/dns_response_verdict_parser_tb.sv
`timescale 1ns / 1ps

module dns_response_verdict_parser_tb;
  import dnsv_pkg::*;

  localparam logic [31:0] SINK_ADDRS [5] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7F00_0001, 32'h0000_00FF, 32'hFFFF_FFFF
  };

  class dns_verdict_board;
    logic [PosW-1:0] pos_cnt;
    phase_e          phase;
    logic [16:0]     skip_cnt;
    logic [15:0]     an_count;
    logic [15:0]     an_passed;
    logic [3:0]      rcode;
    logic [47:0]     rr_fields;
    logic [3:0]      fld_idx;
    logic [31:0]     addr_acc;
    bit              a_found;
    verdict_t        pending_q[$];
    int              mismatches;
    int              verdicts_seen;
    int              status_hits[5];
    int              sink_hits;

    function new();
      restart();
    endfunction

    function void restart();
      pos_cnt   = '0;
      phase     = PH_HEADER;
      skip_cnt  = '0;
      an_count  = '0;
      an_passed = '0;
      rcode     = '0;
      rr_fields = '0;
      fld_idx   = '0;
      addr_acc  = '0;
      a_found   = 1'b0;
    endfunction

    function bit known_sinkhole(logic [31:0] a);
      foreach (SINK_ADDRS[i]) if (SINK_ADDRS[i] == a) return 1'b1;
      return 1'b0;
    endfunction

    function void start_fixed();
      phase     = PH_FIXED;
      fld_idx   = '0;
      rr_fields = '0;
    endfunction

    function void parse_byte(logic [7:0] b);
      if (phase == PH_HEADER) begin
        if (pos_cnt == PosRcode) rcode = b[3:0];
        if (pos_cnt == PosAnHi) an_count = {b, 8'h00};
        if (pos_cnt == PosAnLo) an_count[7:0] = b;
        if (pos_cnt == PosHdrLast) phase = PH_QNAME;
        return;
      end
      if (phase == PH_DONE) return;
      if (skip_cnt != 0) begin
        skip_cnt = skip_cnt - 17'd1;
        return;
      end
      case (phase)
        PH_QNAME: begin
          if (b == 8'h00) begin
            skip_cnt = 17'd4;
            phase    = PH_ANS_FIRST;
          end else if (b[7:6] == PtrMark) begin
            skip_cnt = 17'd5;
            phase    = PH_ANS_FIRST;
          end else begin
            skip_cnt = {9'd0, b};
          end
        end
        PH_ANS_FIRST: begin
          if (an_passed >= an_count) begin
            phase = PH_DONE;
          end else if (b[7:6] == PtrMark) begin
            start_fixed();
            skip_cnt = 17'd1;
          end else if (b == 8'h00) begin
            start_fixed();
          end else begin
            skip_cnt = {9'd0, b};
            phase    = PH_ANS_LABEL;
          end
        end
        PH_ANS_LABEL: begin
          if (b == 8'h00) start_fixed();
          else skip_cnt = {9'd0, b};
        end
        PH_FIXED: begin
          // TTL bytes (4..7) are skipped
          if (fld_idx < 4'd4 || fld_idx >= 4'd8) rr_fields = {rr_fields[39:0], b};
          fld_idx = fld_idx + 4'd1;
          if (fld_idx >= 4'd10) begin
            if (rr_fields[47:32] == TypeA && rr_fields[31:16] == ClassIn &&
                rr_fields[15:0] == RdLenA) begin
              phase    = PH_RDATA;
              fld_idx  = '0;
              addr_acc = '0;
            end else begin
              an_passed = an_passed + 16'd1;
              skip_cnt  = {1'b0, rr_fields[15:0]};
              phase     = PH_ANS_FIRST;
            end
          end
        end
        PH_RDATA: begin
          addr_acc = {addr_acc[23:0], b};
          fld_idx  = fld_idx + 4'd1;
          if (fld_idx >= 4'd4) begin
            a_found = 1'b1;
            phase   = PH_DONE;
          end
        end
        default: phase = PH_DONE;
      endcase
    endfunction

    function void absorb_beat(logic [7:0] b, logic l);
      verdict_t v;
      if (pos_cnt < MaxPos) begin
        parse_byte(b);
        pos_cnt = pos_cnt + PosW'(1);
      end
      if (!l) return;
      v       = '0;
      v.rcode = rcode;
      if (pos_cnt < HdrLen) begin
        v.status = ST_FAIL;
      end else if (rcode == RcodeNxdomain) begin
        v.status   = ST_NXDOMAIN;
        v.nxdomain = 1'b1;
      end else if (rcode != 4'd0) begin
        v.status   = ST_RCODE_ERR;
        v.nxdomain = 1'b1;
      end else if (an_count == 16'd0) begin
        v.status   = ST_NO_ANSWERS;
        v.sinkhole = 1'b1;
      end else if (a_found) begin
        v.status   = ST_FOUND;
        v.address  = addr_acc;
        v.sinkhole = known_sinkhole(addr_acc);
      end else begin
        v.status = ST_FAIL;
      end
      v.blocked = v.nxdomain | v.sinkhole;
      pending_q = {pending_q, v};
      restart();
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: verdict beat with none pending: st=%0d rc=%0h addr=%08h",
                   $time, got.status, got.rcode, got.address);
        return;
      end
      want = pending_q.pop_front();
      verdicts_seen++;
      status_hits[int'(want.status)]++;
      if (want.status == ST_FOUND && want.sinkhole) sink_hits++;
      if (got.status !== want.status || got.rcode !== want.rcode ||
          got.address !== want.address || got.nxdomain !== want.nxdomain ||
          got.sinkhole !== want.sinkhole || got.blocked !== want.blocked) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: verdict mismatch: exp st=%0d rc=%0h addr=%08h nx=%0b sk=%0b bl=%0b",
                   $time, want.status, want.rcode, want.address, want.nxdomain,
                   want.sinkhole, want.blocked);
          $display("%0t:                   got st=%0d rc=%0h addr=%08h nx=%0b sk=%0b bl=%0b",
                   $time, got.status, got.rcode, got.address, got.nxdomain,
                   got.sinkhole, got.blocked);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  rcode_value_o;
  logic [31:0] address_o;
  logic        nxdomain_flag_o;
  logic        sinkhole_flag_o;
  logic        blocked_o;

  dns_response_verdict_parser u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .rcode_value_o  (rcode_value_o),
    .address_o      (address_o),
    .nxdomain_flag_o(nxdomain_flag_o),
    .sinkhole_flag_o(sinkhole_flag_o),
    .blocked_o      (blocked_o)
  );

  dns_verdict_board board = new();
  logic [7:0]       pkt [1024];
  int unsigned      pkt_len;
  bit               burst_mode;
  bit               hold_done;
  int               hold_left;
  int               beats_sent;
  int               packets_sent;
  verdict_t         seen_v;

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("timeout: %0d verdicts still pending", board.pending_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, one long hold-off once traffic is flowing
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && board.verdicts_seen >= 10) begin
      out_ready_i <= 1'b0;
      hold_left   <= 300;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= burst_mode || ($urandom_range(99) >= 32);
    end
  end

  // beat taken at the next rising edge; all inputs are stable at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_v.status   = status_e'(status_o);
      seen_v.rcode    = rcode_value_o;
      seen_v.address  = address_o;
      seen_v.nxdomain = nxdomain_flag_o;
      seen_v.sinkhole = sinkhole_flag_o;
      seen_v.blocked  = blocked_o;
      board.check_verdict(seen_v);
    end
  end

  function automatic void pkt_add(logic [7:0] b);
    pkt[pkt_len] = b;
    pkt_len++;
  endfunction

  function automatic void put_rand(int unsigned n);
    repeat (n) pkt_add(8'($urandom));
  endfunction

  function automatic void put_header(logic [3:0] rc, logic [15:0] an);
    put_rand(3);
    pkt_add({4'($urandom), rc});
    pkt_add(8'h00);
    pkt_add(8'h01);
    pkt_add(an[15:8]);
    pkt_add(an[7:0]);
    put_rand(4);
  endfunction

  function automatic void put_labels(int unsigned n);
    int unsigned len;
    repeat (n) begin
      len = $urandom_range(1, 6);
      pkt_add(8'(len));
      put_rand(len);
    end
    pkt_add(8'h00);
  endfunction

  function automatic void put_record(bit is_a, logic [31:0] ip);
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    case ($urandom_range(2))
      0: begin
        pkt_add({PtrMark, 6'($urandom)});
        put_rand(1);
      end
      1: pkt_add(8'h00);
      default: put_labels($urandom_range(1, 2));
    endcase
    if (is_a) begin
      rtype  = TypeA;
      rclass = ClassIn;
      rdlen  = RdLenA;
    end else begin
      case ($urandom_range(3))
        0: begin rtype = 16'd5;  rclass = ClassIn; rdlen = 16'($urandom_range(0, 12)); end
        1: begin rtype = TypeA;  rclass = ClassIn; rdlen = 16'd6; end
        2: begin rtype = 16'd28; rclass = ClassIn; rdlen = 16'd16; end
        default: begin rtype = TypeA; rclass = 16'd3; rdlen = RdLenA; end
      endcase
    end
    pkt_add(rtype[15:8]);
    pkt_add(rtype[7:0]);
    pkt_add(rclass[15:8]);
    pkt_add(rclass[7:0]);
    put_rand(4);
    pkt_add(rdlen[15:8]);
    pkt_add(rdlen[7:0]);
    if (is_a) begin
      pkt_add(ip[31:24]);
      pkt_add(ip[23:16]);
      pkt_add(ip[15:8]);
      pkt_add(ip[7:0]);
    end else begin
      put_rand(32'(rdlen));
    end
  endfunction

  function automatic void make_response(logic [3:0] rc, logic [15:0] an, int a_slot,
                                        logic [31:0] ip, int unsigned extra);
    int unsigned n_rec;
    pkt_len = 0;
    put_header(rc, an);
    if ($urandom_range(3) == 0) begin
      pkt_add({PtrMark, 6'($urandom)});
      put_rand(1);
    end else begin
      put_labels($urandom_range(1, 3));
    end
    put_rand(4);
    n_rec = (an > 16'd4) ? 4 : an;
    for (int i = 0; i < n_rec; i++) put_record(i == a_slot, ip);
    put_rand(extra);
  endfunction

  function automatic void cut_to(int unsigned n);
    if (pkt_len > n) pkt_len = n;
  endfunction

  function automatic void pad_to(int unsigned n);
    while (pkt_len < n) pkt_add(8'($urandom));
  endfunction

  task automatic send_beat(logic [7:0] b, logic l);
    bit took;
    while (!burst_mode && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    board.absorb_beat(b, l);
    beats_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_len; i++) send_beat(pkt[i], i == pkt_len - 1);
    packets_sent++;
  endtask

  initial begin
    int          n_rnd;
    int          pick;
    logic [3:0]  rc;
    logic [15:0] an;
    logic [31:0] ip;
    int          fails;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    pkt_len = 0;
    pkt_add(8'hFF);
    send_packet();
    make_response(RcodeNxdomain, 16'd1, 0, 32'h0A00_0001, 0);
    cut_to(11);
    send_packet();
    make_response(RcodeNxdomain, 16'd1, 0, 32'h0A00_0001, 0);
    send_packet();
    make_response(4'hF, 16'd2, 1, 32'h0A00_0002, 0);
    send_packet();
    make_response(4'h1, 16'd0, -1, 32'h0, 0);
    send_packet();
    make_response(4'h0, 16'd0, -1, 32'h0, 3);
    send_packet();
    foreach (SINK_ADDRS[k]) begin
      make_response(4'h0, 16'd1, 0, SINK_ADDRS[k], 0);
      send_packet();
    end
    make_response(4'h0, 16'd3, 2, 32'hC0A8_0001, 2);
    send_packet();
    make_response(4'h0, 16'hFFFF, 1, 32'h0808_0808, 0);
    send_packet();
    // count exhausted, trailing bytes ignored
    make_response(4'h0, 16'd2, -1, 32'h0, 6);
    send_packet();
    // A rdata cut short
    make_response(4'h0, 16'd1, 0, 32'h7F00_0002, 0);
    cut_to(pkt_len - 2);
    send_packet();
    // 0x40/0x80 prefixes are plain label lengths
    pkt_len = 0;
    put_header(4'h0, 16'd1);
    pkt_add(8'h41);
    put_rand(65);
    pkt_add(8'h80);
    put_rand(128);
    pkt_add(8'h00);
    put_rand(4);
    put_record(1'b1, 32'h0102_0304);
    send_packet();
    // pointer mark after a label in an answer name counts as a length
    pkt_len = 0;
    put_header(4'h0, 16'd1);
    put_labels(1);
    put_rand(4);
    pkt_add(8'h01);
    put_rand(1);
    pkt_add(8'hC0);
    pkt_add(8'h0C);
    put_record(1'b1, 32'h0506_0708);
    send_packet();
    // A rdata straddles the parse limit, last mark past the limit
    pkt_len = 0;
    put_header(4'h0, 16'd1);
    repeat (7) begin
      pkt_add(8'd63);
      put_rand(63);
    end
    pkt_add(8'd32);
    put_rand(32);
    pkt_add(8'h00);
    put_rand(4);
    pkt_add(8'hC0);
    pkt_add(8'h0C);
    pkt_add(8'h00);
    pkt_add(8'h01);
    pkt_add(8'h00);
    pkt_add(8'h01);
    put_rand(4);
    pkt_add(8'h00);
    pkt_add(8'h04);
    pad_to(520);
    send_packet();

    // random
    n_rnd = 0;
    while (beats_sent < 1900 || n_rnd < 12) begin
      if (n_rnd == 2) begin
        // let the block drain completely before going on
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (board.pending_q.size() != 0) @(posedge clk_i);
      end
      if (n_rnd == 4) burst_mode = 1'b1;
      if (n_rnd == 10) burst_mode = 1'b0;

      pick = $urandom_range(99);
      if ($urandom_range(99) < 75) rc = 4'h0;
      else if ($urandom_range(99) < 40) rc = RcodeNxdomain;
      else rc = 4'($urandom_range(1, 15));
      case ($urandom_range(9))
        0:       an = 16'd0;
        9:       an = 16'($urandom);
        default: an = 16'($urandom_range(1, 3));
      endcase
      if ($urandom_range(99) < 40) ip = SINK_ADDRS[$urandom_range(4)];
      else ip = $urandom;
      make_response(rc, an, int'($urandom_range(0, 4)) - 1, ip,
                    ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
      if (pick < 15) begin
        cut_to($urandom_range(1, pkt_len - 1));
      end else if (pick < 30) begin
        pkt_len = 0;
        put_rand($urandom_range(1, 30));
      end
      send_packet();
      n_rnd++;
    end
    in_valid_i <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    fails = board.mismatches + board.pending_q.size();
    $display("Sent %0d packets in %0d bytes, checked %0d verdicts (%0d mismatches).",
             packets_sent, beats_sent, board.verdicts_seen, board.mismatches);
    $display("Verdicts: nxdomain %0d, rcode error %0d, no answers %0d,",
             board.status_hits[0], board.status_hits[1], board.status_hits[2]);
    $display("  A found %0d (%0d sinkhole), parse fail %0d.",
             board.status_hits[3], board.sink_hits, board.status_hits[4]);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
